>>> sv/bfba_pkg.sv
// Shared types and constants of the best-fit block allocator.
package bfba_pkg;

	// Field and register types
	typedef logic [0:0]  cmd_code_t;
	typedef logic [3:0]  idx_t;
	typedef logic [15:0] amt_t;
	typedef logic [15:0] limit_t;
	typedef logic [4:0]  count_t;
	typedef logic [0:0]  cfg_idx_t;
	typedef logic [15:0] cfg_data_t;

	// Input command codes
	localparam cmd_code_t CMD_LOAD  = 1'b0;
	localparam cmd_code_t CMD_ALLOC = 1'b1;

	// Configuration register indexes
	localparam cfg_idx_t REG_LEFTOVER_LIMIT = 1'b0;
	localparam cfg_idx_t REG_BLOCKS_IN_USE  = 1'b1;

	// Register reset values
	localparam limit_t LIMIT_RESET  = 16'd10000;
	localparam count_t BLOCKS_RESET = 5'd16;

	// Controller to datapath commands
	typedef struct packed {
		logic start;    // latch an allocate transaction, clear the best candidate
		logic load_wr;  // write a loaded capacity into the table
		logic rd_en;    // read the entry at the scan pointer and advance
		logic wb;       // charge the chosen block and load the result register
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_alloc;  // incoming transaction is an allocate
		logic empty;     // no block to scan
		logic last;      // scan pointer is at the final entry
		logic out_free;  // result register can take a new result
	} dp_status_t;

endpackage

>>> sv/best_fit_block_allocator.sv
// Top level of the best-fit block allocator: controller plus datapath.
//
// Input channel (in_valid/in_ready) carries command, block_index and amount.
// A load transaction writes one block's capacity in its acceptance cycle and
// gives no result; a block_index beyond the table is dropped.
// An allocate transaction scans blocks 0 .. blocks_in_use-1, one table entry
// per cycle through the single read port of the capacity memory, then charges
// the best-fitting block and posts one result on the output channel
// (out_valid/out_ready: granted, chosen_block, leftover).
// An allocate reads N entries, N being blocks_in_use clamped to the table
// depth, then compares the last entry read and charges the chosen block;
// the charge loads the result register that drives out_valid, and the input
// is ready again once the charge is done. When N is 0 the allocate skips the
// reads and the compare and goes straight to its charge step.
// A stalled receiver holds the result in the output register; a following
// load or allocate is still accepted, and an allocate waits in its charge
// step until the register frees.
// Configuration (cfg_write/cfg_index/cfg_data) must be written while idle; the block does not enforce it.
// Reset clears all capacities to zero at once through per-entry valid bits,
// sets leftover_limit to 10000 and blocks_in_use to 16.
module best_fit_block_allocator #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  bfba_pkg::cfg_idx_t  cfg_index,
	input  bfba_pkg::cfg_data_t cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  bfba_pkg::cmd_code_t command,
	input  bfba_pkg::idx_t      block_index,
	input  bfba_pkg::amt_t      amount,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                granted,
	output bfba_pkg::idx_t      chosen_block,
	output bfba_pkg::amt_t      leftover
);

	bfba_pkg::ctrl_cmd_t  cmd;
	bfba_pkg::dp_status_t status;

	bfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bfba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.block_index  (block_index),
		.amount       (amount),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted      (granted),
		.chosen_block (chosen_block),
		.leftover     (leftover)
	);

endmodule

>>> sv/bfba_datapath.sv
// Datapath: configuration registers, capacity table, best-fit compare and result register.
module bfba_datapath #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  bfba_pkg::cfg_idx_t   cfg_index,
	input  bfba_pkg::cfg_data_t  cfg_data,
	input  bfba_pkg::cmd_code_t  command,
	input  bfba_pkg::idx_t       block_index,
	input  bfba_pkg::amt_t       amount,
	input  bfba_pkg::ctrl_cmd_t  cmd,
	output bfba_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 granted,
	output bfba_pkg::idx_t       chosen_block,
	output bfba_pkg::amt_t       leftover
);

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int LW = (SIZE_BITS > $bits(bfba_pkg::limit_t)) ?
		SIZE_BITS : $bits(bfba_pkg::limit_t);

	bfba_pkg::limit_t        limit_q;
	bfba_pkg::count_t        blocks_q;
	logic [CW-1:0]           count_sat;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           ptr_q;
	logic [CW:0]             ptr_next_w;
	logic [SIZE_BITS-1:0]    amt_q;
	logic                    in_range;

	logic [SIZE_BITS-1:0]    mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0]   valid_q;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [SIZE_BITS-1:0]    wr_data;

	logic [SIZE_BITS-1:0]    rd_data_s1;
	logic                    rd_vld_s1;
	logic                    scan_s1;
	logic [AW-1:0]           idx_s1;

	logic [SIZE_BITS-1:0]    cap_w;
	logic [SIZE_BITS-1:0]    left_w;
	logic                    take;
	logic                    found_q;
	logic [AW-1:0]           best_idx_q;
	logic [SIZE_BITS-1:0]    best_left_q;

	logic                    out_valid_q;
	logic                    granted_q;
	bfba_pkg::idx_t          chosen_q;
	bfba_pkg::amt_t          leftover_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= bfba_pkg::LIMIT_RESET;
			blocks_q <= bfba_pkg::BLOCKS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				bfba_pkg::REG_LEFTOVER_LIMIT: limit_q  <= cfg_data;
				bfba_pkg::REG_BLOCKS_IN_USE:  blocks_q <= cfg_data[$bits(bfba_pkg::count_t)-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the block count to the table depth
	assign count_sat = (int'(blocks_q) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(blocks_q);
	assign in_range  = int'(block_index) < NUM_BLOCKS;

	// Latch request size and scan length, reset the scan pointer
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			amt_q   <= SIZE_BITS'(amount);
			count_q <= count_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.start) begin
			ptr_q <= '0;
		end else if (cmd.rd_en) begin
			ptr_q <= ptr_q + AW'(1);
		end
	end

	assign ptr_next_w = (CW+1)'(ptr_q) + (CW+1)'(1);

	// Table write: a load or the charge of the chosen block
	assign wr_en   = (cmd.load_wr && in_range) || (cmd.wb && found_q);
	assign wr_addr = cmd.wb ? best_idx_q : AW'(block_index);
	assign wr_data = cmd.wb ? best_left_q : SIZE_BITS'(amount);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[ptr_q];
		end
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_s1 <= valid_q[ptr_q];
		idx_s1    <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= cmd.rd_en;
		end
	end

	// Compare the entry read last cycle against the best candidate
	assign cap_w  = rd_vld_s1 ? rd_data_s1 : '0;
	assign left_w = cap_w - amt_q;
	assign take   = scan_s1 && (cap_w >= amt_q) && (LW'(left_w) < LW'(limit_q))
		&& (!found_q || (left_w < best_left_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= idx_s1;
			best_left_q <= left_w;
		end
	end

	// Result register: hold until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wb) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			granted_q  <= found_q;
			chosen_q   <= found_q ? bfba_pkg::idx_t'(best_idx_q) : '0;
			leftover_q <= found_q ? bfba_pkg::amt_t'(best_left_q) : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign chosen_block = chosen_q;
	assign leftover     = leftover_q;

	// Status to the controller
	assign status.is_alloc = (command == bfba_pkg::CMD_ALLOC);
	assign status.empty    = (count_sat == '0);
	assign status.last     = (ptr_next_w == (CW+1)'(count_q));
	assign status.out_free = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> ((CW+1)'(ptr_q) < (CW+1)'(count_q)))
		else $error("scan read beyond latched block count");

	a_wb_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |=> out_valid_q)
		else $error("charge cycle did not load the result register");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (!found_q && (ptr_q == '0)))
		else $error("new allocate did not clear the search");
`endif

endmodule

>>> sv/bfba_ctrl.sv
// Controller: sequences load, scan, compare and charge of each transaction.
module bfba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bfba_pkg::dp_status_t status,
	output bfba_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_EVAL = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (status.is_alloc) begin
						cmd.start = 1'b1;
						state_d   = status.empty ? S_DONE : S_SCAN;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (status.last) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.wb  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !status.out_free) |=> (state_q == S_DONE))
		else $error("left the charge state while the result register was full");
`endif

endmodule
